/* design/chse_pkg.sv */
package chse_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_WIDTH = 5;

    localparam logic [2:0] REG_START_POSITION = 3'd0;
    localparam logic [2:0] REG_START_VELOCITY = 3'd1;
    localparam logic [2:0] REG_END_POSITION = 3'd2;
    localparam logic [2:0] REG_END_VELOCITY = 3'd3;
    localparam logic [2:0] REG_DURATION = 3'd4;

    localparam logic [1:0] ACT_POSITION = 2'd0;
    localparam logic [1:0] ACT_VELOCITY = 2'd1;
    localparam logic [1:0] ACT_ACCEL = 2'd2;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] time_point;
        logic [1:0] action;
    } chse_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] value;
        logic saturated;
    } chse_out_t;

endpackage

/* design/cubic_hermite_segment_eval_unit.sv */
// Path: input register, divider chain for t/duration, polynomial and weighting registers,
// rounding register, divider chain for the final scaling and output register, in that order.
// Both dividers give one bit per stage; values are Q16.16 with the default parameters.
// Throughput: one word per cycle; the whole pipeline holds only while an output word waits
// with m_ready low.
// Reset (aresetn low, synchronous) clears all valid bits and sets the boundary registers to
// zero and the duration to one half.
module cubic_hermite_segment_eval_unit
    import chse_pkg::*;
#(
    parameter int FRAC_BITS_P = FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  chse_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output chse_out_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    localparam int W = DATA_WIDTH;
    localparam int F = FRAC_BITS_P;
    localparam int SW = F + 1;
    localparam int CW = F + 5;
    localparam int DPW = W + 1;
    localparam int PAW = DPW + CW;
    localparam int VBW = W + CW;
    localparam int VW = VBW + 1;
    localparam int H = VW / 2;
    localparam int HW = VW - H;
    localparam int NW0 = W + 2 * F + 6;
    localparam int NW1 = 2 * W + F + 6;
    localparam int NW = ((NW0 > NW1) ? NW0 : NW1) + 2;
    localparam int DA = 2 * F + 1;
    localparam int DB = W + F - 1;
    localparam int DC = 2 * W - 2;
    localparam int DAB = (DA > DB) ? DA : DB;
    localparam int DENW = (DAB > DC) ? DAB : DC;
    localparam int RW = DENW + 1;
    localparam int TOPW = NW + 1 - W;
    localparam int CMPW = (TOPW > RW) ? TOPW : RW;
    localparam int MIN_RAW = ((1 << F) + 500) / 1000;
    localparam int MIN_DUR_I = (MIN_RAW < 1) ? 1 : MIN_RAW;
    localparam logic [W-2:0] MIN_DUR = (W-1)'(MIN_DUR_I);
    localparam logic [W-2:0] DUR_RESET = (W-1)'(1) << (F - 1);
    localparam logic [2*SW-1:0] HALF_SQ = (2*SW)'(1) << (F - 1);
    localparam logic signed [CW-1:0] ONE_C = CW'(1) << F;
    localparam logic [DENW-1:0] DEN_POS = DENW'(1) << (2 * F);

    logic signed [W-1:0] start_position_reg;
    logic signed [W-1:0] start_velocity_reg;
    logic signed [W-1:0] end_position_reg;
    logic signed [W-1:0] end_velocity_reg;
    logic [W-2:0]        duration_reg;
    logic [W-2:0]        dur_wr;
    logic                cfg_wr;

    logic en;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign dur_wr = (pwdata[W-2:0] < MIN_DUR) ? MIN_DUR : pwdata[W-2:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_position_reg <= '0;
            start_velocity_reg <= '0;
            end_position_reg <= '0;
            end_velocity_reg <= '0;
            duration_reg <= DUR_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_START_POSITION: start_position_reg <= pwdata;
                REG_START_VELOCITY: start_velocity_reg <= pwdata;
                REG_END_POSITION: end_position_reg <= pwdata;
                REG_END_VELOCITY: end_velocity_reg <= pwdata;
                REG_DURATION: duration_reg <= dur_wr;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_START_POSITION: prdata = start_position_reg;
            REG_START_VELOCITY: prdata = start_velocity_reg;
            REG_END_POSITION: prdata = end_position_reg;
            REG_END_VELOCITY: prdata = end_velocity_reg;
            REG_DURATION: prdata = {1'b0, duration_reg};
            default: prdata = '0;
        endcase
    end

    // Normalized time: restoring division, one quotient bit per stage.
    logic [F:0]   sd_valid_reg;
    logic [W-2:0] sd_rem_reg [0:F];
    logic [F-1:0] sd_q_reg [0:F];
    logic [1:0]   sd_act_reg [0:F];
    logic [F:0]   sd_zero_reg;
    logic [F:0]   sd_one_reg;
    logic [W-2:0] sd_rem_next [1:F];
    logic [F-1:0] sd_q_next [1:F];

    assign en = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sd_valid_reg[0] <= 1'b0;
        end else if (en) begin
            sd_valid_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sd_rem_reg[0] <= s_data.time_point[W-2:0];
            sd_q_reg[0] <= '0;
            sd_act_reg[0] <= s_data.action;
            sd_zero_reg[0] <= s_data.time_point[W-1] || (s_data.time_point == '0);
            sd_one_reg[0] <= !s_data.time_point[W-1]
                && (s_data.time_point[W-2:0] >= duration_reg);
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_sdiv
        logic [W-1:0] sd_tmp;
        logic         sd_ge;

        always_comb begin
            sd_tmp = {sd_rem_reg[k], 1'b0};
            sd_ge = sd_tmp >= {1'b0, duration_reg};
            sd_rem_next[k+1] = sd_ge ? (W-1)'(sd_tmp - {1'b0, duration_reg})
                                     : (W-1)'(sd_tmp);
            sd_q_next[k+1] = {sd_q_reg[k][F-2:0], sd_ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sd_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                sd_valid_reg[k+1] <= sd_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sd_rem_reg[k+1] <= sd_rem_next[k+1];
                sd_q_reg[k+1] <= sd_q_next[k+1];
                sd_act_reg[k+1] <= sd_act_reg[k];
                sd_zero_reg[k+1] <= sd_zero_reg[k];
                sd_one_reg[k+1] <= sd_one_reg[k];
            end
        end
    end

    // Polynomial and weighting stages.
    logic [9:2] pv_reg;
    logic [1:0] act2_reg, act3_reg, act4_reg, act5_reg, act6_reg, act7_reg, act8_reg;
    logic [1:0] act9_reg;
    logic [SW-1:0] s2s_reg, s3s_reg, s4s_reg;
    logic [SW-1:0] s3sq_reg, s4sq_reg;
    logic [SW-1:0] s4cu_reg;
    logic [SW-1:0] s_next;
    logic [2*SW-1:0] sq_prod, cu_prod;
    logic signed [CW-1:0] a5_reg, b5_reg, c5_reg;
    logic signed [CW-1:0] a_next, b_next, c_next;
    logic signed [CW-1:0] sx, s2x, s3x;
    logic signed [DPW-1:0] dp5_reg;
    logic [DENW-1:0] den5_reg, den6_reg, den7_reg, den8_reg, den9_reg;
    logic [DENW-1:0] den_next;
    logic [2*W-3:0] dq_sq;
    logic signed [PAW-1:0] pa6_reg;
    logic signed [VBW-1:0] vb6_reg, vc6_reg;
    logic signed [NW-1:0] part7_reg, part8_reg;
    logic signed [NW-1:0] part_next;
    logic signed [VW-1:0] vsum7_reg;
    logic signed [VW-1:0] vsum_next;
    logic [H+W-2:0] plo8_reg;
    logic signed [HW+W-1:0] phi8_reg;
    logic signed [NW-1:0] n9_reg;
    logic signed [NW-1:0] n_next;

    assign s_next = sd_one_reg[F] ? (SW'(1) << F)
                  : (sd_zero_reg[F] ? '0 : {1'b0, sd_q_reg[F]});
    assign sq_prod = s2s_reg * s2s_reg + HALF_SQ;
    assign cu_prod = s3sq_reg * s3s_reg + HALF_SQ;
    assign dq_sq = duration_reg * duration_reg;

    always_comb begin
        sx = signed'(CW'(s4s_reg));
        s2x = signed'(CW'(s4sq_reg));
        s3x = signed'(CW'(s4cu_reg));
        unique case (act4_reg)
            ACT_POSITION: begin
                a_next = CW'(3 * s2x - 2 * s3x);
                b_next = CW'(s3x - 2 * s2x + sx);
                c_next = CW'(s3x - s2x);
                den_next = DEN_POS;
            end
            ACT_VELOCITY: begin
                a_next = CW'(6 * sx - 6 * s2x);
                b_next = CW'(3 * s2x - 4 * sx + ONE_C);
                c_next = CW'(3 * s2x - 2 * sx);
                den_next = DENW'(duration_reg) << F;
            end
            ACT_ACCEL: begin
                a_next = CW'(6 * ONE_C - 12 * sx);
                b_next = CW'(6 * sx - 4 * ONE_C);
                c_next = CW'(6 * sx - 2 * ONE_C);
                den_next = DENW'(dq_sq);
            end
            default: begin
                a_next = '0;
                b_next = '0;
                c_next = '0;
                den_next = DEN_POS;
            end
        endcase
    end

    always_comb begin
        vsum_next = VW'(vb6_reg) + VW'(vc6_reg);
        part_next = NW'(pa6_reg) <<< F;
        if (act6_reg == ACT_POSITION) begin
            part_next = part_next + (NW'(start_position_reg) <<< (2 * F));
        end
        n_next = part8_reg + (NW'(phi8_reg) <<< H) + signed'(NW'(plo8_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= '0;
        end else if (en) begin
            pv_reg <= {pv_reg[8:2], sd_valid_reg[F]};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act2_reg <= sd_act_reg[F];
            s2s_reg <= s_next;
            act3_reg <= act2_reg;
            s3s_reg <= s2s_reg;
            s3sq_reg <= sq_prod[F+SW-1:F];
            act4_reg <= act3_reg;
            s4s_reg <= s3s_reg;
            s4sq_reg <= s3sq_reg;
            s4cu_reg <= cu_prod[F+SW-1:F];
            act5_reg <= act4_reg;
            a5_reg <= a_next;
            b5_reg <= b_next;
            c5_reg <= c_next;
            dp5_reg <= DPW'(end_position_reg) - DPW'(start_position_reg);
            den5_reg <= den_next;
            act6_reg <= act5_reg;
            pa6_reg <= dp5_reg * a5_reg;
            vb6_reg <= start_velocity_reg * b5_reg;
            vc6_reg <= end_velocity_reg * c5_reg;
            den6_reg <= den5_reg;
            act7_reg <= act6_reg;
            part7_reg <= part_next;
            vsum7_reg <= vsum_next;
            den7_reg <= den6_reg;
            act8_reg <= act7_reg;
            part8_reg <= part7_reg;
            plo8_reg <= vsum7_reg[H-1:0] * duration_reg;
            phi8_reg <= signed'(vsum7_reg[VW-1:H]) * signed'({1'b0, duration_reg});
            den8_reg <= den7_reg;
            act9_reg <= act8_reg;
            n9_reg <= n_next;
            den9_reg <= den8_reg;
        end
    end

    // Rounded scaling: quotient of (2|n| + den) by 2*den, one bit per stage.
    logic [NW-1:0] mag;
    logic          nv_reg;
    logic [1:0]    act10_reg;
    logic          neg10_reg;
    logic [NW:0]   num10_reg;
    logic [RW-1:0] d2_10_reg;
    logic [TOPW-1:0] top;
    logic          ovf_next;

    assign mag = n9_reg[NW-1] ? NW'(-n9_reg) : NW'(n9_reg);
    assign top = num10_reg[NW:W];
    assign ovf_next = CMPW'(top) >= CMPW'(d2_10_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nv_reg <= 1'b0;
        end else if (en) begin
            nv_reg <= pv_reg[9];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act10_reg <= act9_reg;
            neg10_reg <= n9_reg[NW-1];
            num10_reg <= {mag, 1'b0} + (NW+1)'(den9_reg);
            d2_10_reg <= {den9_reg, 1'b0};
        end
    end

    logic [W:0]    dv_valid_reg;
    logic [RW-1:0] dv_rem_reg [0:W];
    logic [W-1:0]  dv_q_reg [0:W];
    logic [W-1:0]  dv_low_reg [0:W];
    logic [RW-1:0] dv_d2_reg [0:W];
    logic [1:0]    dv_act_reg [0:W];
    logic [W:0]    dv_neg_reg;
    logic [W:0]    dv_ovf_reg;
    logic [RW-1:0] dv_rem_next [1:W];
    logic [W-1:0]  dv_q_next [1:W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (en) begin
            dv_valid_reg[0] <= nv_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0] <= ovf_next ? '0 : RW'(top);
            dv_q_reg[0] <= '0;
            dv_low_reg[0] <= num10_reg[W-1:0];
            dv_d2_reg[0] <= d2_10_reg;
            dv_act_reg[0] <= act10_reg;
            dv_neg_reg[0] <= neg10_reg;
            dv_ovf_reg[0] <= ovf_next;
        end
    end

    for (genvar k = 0; k < W; k++) begin : g_qdiv
        logic [RW:0] dv_tmp;
        logic        dv_ge;

        always_comb begin
            dv_tmp = {dv_rem_reg[k], dv_low_reg[k][W-1-k]};
            dv_ge = dv_tmp >= {1'b0, dv_d2_reg[k]};
            dv_rem_next[k+1] = dv_ge ? RW'(dv_tmp - {1'b0, dv_d2_reg[k]}) : RW'(dv_tmp);
            dv_q_next[k+1] = {dv_q_reg[k][W-2:0], dv_ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                dv_valid_reg[k+1] <= dv_valid_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[k+1] <= dv_rem_next[k+1];
                dv_q_reg[k+1] <= dv_q_next[k+1];
                dv_low_reg[k+1] <= dv_low_reg[k];
                dv_d2_reg[k+1] <= dv_d2_reg[k];
                dv_act_reg[k+1] <= dv_act_reg[k];
                dv_neg_reg[k+1] <= dv_neg_reg[k];
                dv_ovf_reg[k+1] <= dv_ovf_reg[k];
            end
        end
    end

    // Saturation and output word.
    logic [W-1:0] q_fin;
    logic [W-1:0] lim;
    logic         sat_next;
    chse_out_t    out_next;
    chse_out_t    out_reg;
    logic         out_valid_reg;

    assign q_fin = dv_q_reg[W];
    assign lim = dv_neg_reg[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign sat_next = dv_ovf_reg[W] || (q_fin > lim);

    always_comb begin
        if (dv_act_reg[W] == ACT_NONE) begin
            out_next.value = '0;
            out_next.saturated = 1'b0;
        end else begin
            out_next.saturated = sat_next;
            if (sat_next) begin
                out_next.value = signed'(dv_neg_reg[W] ? W'(-lim) : lim);
            end else begin
                out_next.value = signed'(dv_neg_reg[W] ? W'(-q_fin) : q_fin);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data = out_reg;

endmodule
